>>> rtl/pls_pkg.sv
// Shared types and constants of the token scanner: character codes, scan modes,
// token kinds, error codes and the step record passed from scanner to queue.
// No dependencies.
package pls_pkg;

   typedef logic [7:0] char_type;
   typedef logic [4:0] kind_type;

   typedef enum logic [3:0] {
      M_IDLE     = 4'd0,
      M_NAME     = 4'd1,
      M_NUMBER   = 4'd2,
      M_COLON    = 4'd3,
      M_GT       = 4'd4,
      M_LT       = 4'd5,
      M_SLASH    = 4'd6,
      M_BRACE    = 4'd7,
      M_STAR     = 4'd8,
      M_STARSTAR = 4'd9,
      M_STRING   = 4'd10,
      M_QUOTE    = 4'd11
   } mode_type;

   typedef enum logic [1:0] {
      NL_NONE     = 2'd0,
      NL_AFTER_LF = 2'd1,
      NL_AFTER_CR = 2'd2
   } newline_type;

   typedef enum logic [1:0] {
      ERR_OK           = 2'd0,
      ERR_UNEXPECTED   = 2'd1,
      ERR_BAD_CHAR     = 2'd2,
      ERR_UNTERMINATED = 2'd3
   } err_type;

   localparam kind_type KIND_NAME      = 5'd0;
   localparam kind_type KIND_NUMBER    = 5'd1;
   localparam kind_type KIND_STRING    = 5'd2;
   localparam kind_type KIND_PLUS      = 5'd3;
   localparam kind_type KIND_MINUS     = 5'd4;
   localparam kind_type KIND_TIMES     = 5'd5;
   localparam kind_type KIND_EQUAL     = 5'd6;
   localparam kind_type KIND_LPAREN    = 5'd7;
   localparam kind_type KIND_RPAREN    = 5'd8;
   localparam kind_type KIND_LBRACKET  = 5'd9;
   localparam kind_type KIND_RBRACKET  = 5'd10;
   localparam kind_type KIND_PERIOD    = 5'd11;
   localparam kind_type KIND_COMMA     = 5'd12;
   localparam kind_type KIND_SEMI      = 5'd13;
   localparam kind_type KIND_BECOMES   = 5'd14;
   localparam kind_type KIND_COLON     = 5'd15;
   localparam kind_type KIND_GE        = 5'd16;
   localparam kind_type KIND_GT        = 5'd17;
   localparam kind_type KIND_NE        = 5'd18;
   localparam kind_type KIND_LE        = 5'd19;
   localparam kind_type KIND_LT        = 5'd20;

   localparam char_type CH_TAB      = 8'h09;
   localparam char_type CH_LF       = 8'h0A;
   localparam char_type CH_CR       = 8'h0D;
   localparam char_type CH_SPACE    = 8'h20;
   localparam char_type CH_GRAPH_LO = 8'h21;
   localparam char_type CH_GRAPH_HI = 8'h7E;
   localparam char_type CH_QUOTE    = 8'h27;
   localparam char_type CH_LPAREN   = 8'h28;
   localparam char_type CH_RPAREN   = 8'h29;
   localparam char_type CH_STAR     = 8'h2A;
   localparam char_type CH_PLUS     = 8'h2B;
   localparam char_type CH_COMMA    = 8'h2C;
   localparam char_type CH_MINUS    = 8'h2D;
   localparam char_type CH_PERIOD   = 8'h2E;
   localparam char_type CH_SLASH    = 8'h2F;
   localparam char_type CH_DIGIT_0  = 8'h30;
   localparam char_type CH_DIGIT_9  = 8'h39;
   localparam char_type CH_COLON    = 8'h3A;
   localparam char_type CH_SEMI     = 8'h3B;
   localparam char_type CH_LT       = 8'h3C;
   localparam char_type CH_EQUAL    = 8'h3D;
   localparam char_type CH_GT       = 8'h3E;
   localparam char_type CH_UPPER_A  = 8'h41;
   localparam char_type CH_UPPER_Z  = 8'h5A;
   localparam char_type CH_LBRACKET = 8'h5B;
   localparam char_type CH_RBRACKET = 8'h5D;
   localparam char_type CH_LOWER_A  = 8'h61;
   localparam char_type CH_LOWER_Z  = 8'h7A;
   localparam char_type CH_LBRACE   = 8'h7B;
   localparam char_type CH_RBRACE   = 8'h7D;

   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = 2;
   localparam int QUEUE_CNT_BITS = 3;

   // One accepted character yields at most two results; the second one is
   // always a one-character symbol or an error, so it needs no length field.
   typedef struct packed {
      logic     two;
      kind_type kind0;
      err_type  err0;
      kind_type kind1;
      err_type  err1;
   } step_type;

endpackage

>>> rtl/pascal_like_token_scanner.sv
// Top level of the token scanner: front end, step queue and result serializer.
// Depends on pls_pkg, pls_front, pls_queue and pls_back.
//
//   Channel   Ports                                    Transfer when
//   input     push, full, req_char_code, req_end_marker   push && !full
//   result    empty, pop, rsp_token_kind, rsp_token_length,
//             rsp_line_number, rsp_error_code, rsp_last    pop && !empty
//
// One character or end marker is taken per cycle unless full; the front end updates
// its mode and writes any results as one record into a four-entry queue. Results
// leave one per cycle while popped; a character that yields two results needs two
// pops. full rises when the queue holds four records with results to deliver. Reset
// clears the mode, the queue and the serializer and sets the line count to one.
module pascal_like_token_scanner #(
   parameter int LINE_BITS   = 16,
   parameter int LENGTH_BITS = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   output logic                   full,
   input  logic [7:0]             req_char_code,
   input  logic                   req_end_marker,
   output logic                   empty,
   input  logic                   pop,
   output logic [4:0]             rsp_token_kind,
   output logic [LENGTH_BITS-1:0] rsp_token_length,
   output logic [LINE_BITS-1:0]   rsp_line_number,
   output logic [1:0]             rsp_error_code,
   output logic                   rsp_last
);
   import pls_pkg::*;

   logic                   accept, step_push, q_pop;
   step_type               step, q_step;
   logic [LENGTH_BITS-1:0] step_length, q_length;
   logic [LINE_BITS-1:0]   step_line, q_line;

   assign accept = push && !full;

   pls_front #(
      .LINE_BITS  (LINE_BITS),
      .LENGTH_BITS(LENGTH_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .char_code  (req_char_code),
      .end_marker (req_end_marker),
      .step_push  (step_push),
      .step       (step),
      .step_length(step_length),
      .step_line  (step_line)
   );

   pls_queue #(
      .LINE_BITS  (LINE_BITS),
      .LENGTH_BITS(LENGTH_BITS)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (step_push),
      .step_in   (step),
      .length_in (step_length),
      .line_in   (step_line),
      .full      (full),
      .pop       (q_pop),
      .empty     (empty),
      .step_out  (q_step),
      .length_out(q_length),
      .line_out  (q_line)
   );

   pls_back #(
      .LINE_BITS  (LINE_BITS),
      .LENGTH_BITS(LENGTH_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_empty     (empty),
      .q_step      (q_step),
      .q_length    (q_length),
      .q_line      (q_line),
      .q_pop       (q_pop),
      .pop         (pop),
      .token_kind  (rsp_token_kind),
      .token_length(rsp_token_length),
      .line_number (rsp_line_number),
      .error_code  (rsp_error_code),
      .last        (rsp_last)
   );

endmodule

>>> rtl/pls_front.sv
// Scanner front end: holds the mode, newline partner, line count and token length,
// and turns each accepted character or end marker into at most one step record.
// Depends on pls_pkg.
module pls_front #(
   parameter int LINE_BITS   = 16,
   parameter int LENGTH_BITS = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  pls_pkg::char_type      char_code,
   input  logic                   end_marker,
   output logic                   step_push,
   output pls_pkg::step_type      step,
   output logic [LENGTH_BITS-1:0] step_length,
   output logic [LINE_BITS-1:0]   step_line
);
   import pls_pkg::*;

   mode_type               mode_ff, mode_in;
   newline_type            nl_ff, nl_in;
   logic [LINE_BITS-1:0]   line_ff, line_in, line_inc;
   logic [LENGTH_BITS-1:0] len_ff, len_in, len_inc;

   logic is_blank, is_nl, is_digit, is_alpha, is_alnum, is_graph, absorbed;

   mode_type i_mode;
   logic     i_start, i_nl, i_emit;
   kind_type i_kind;
   err_type  i_err;

   logic                   tok_v, tok_idle;
   kind_type               tok_kind;
   err_type                tok_err;
   logic [LENGTH_BITS-1:0] tok_len;
   logic                   run_idle, take_nl;

   assign is_blank = (char_code == CH_SPACE) || (char_code == CH_TAB);
   assign is_nl    = (char_code == CH_LF) || (char_code == CH_CR);
   assign is_digit = (char_code >= CH_DIGIT_0) && (char_code <= CH_DIGIT_9);
   assign is_alpha = ((char_code >= CH_UPPER_A) && (char_code <= CH_UPPER_Z)) ||
                     ((char_code >= CH_LOWER_A) && (char_code <= CH_LOWER_Z));
   assign is_alnum = is_alpha || is_digit;
   assign is_graph = is_blank || is_nl ||
                     ((char_code >= CH_GRAPH_LO) && (char_code <= CH_GRAPH_HI));
   assign absorbed = ((nl_ff == NL_AFTER_LF) && (char_code == CH_CR)) ||
                     ((nl_ff == NL_AFTER_CR) && (char_code == CH_LF));

   assign line_inc = (&line_ff) ? line_ff : line_ff + 1'b1;
   assign len_inc  = (&len_ff) ? len_ff : len_ff + 1'b1;

   // Classification of a character seen in idle mode, used both for a fresh
   // character and for the one that ends a multi-character token.
   always_comb begin
      i_mode  = M_IDLE;
      i_start = 1'b0;
      i_nl    = 1'b0;
      i_emit  = 1'b0;
      i_kind  = KIND_NAME;
      i_err   = ERR_OK;
      priority if (is_blank) begin
      end else if (is_nl) begin
         i_nl = 1'b1;
      end else if (is_alpha) begin
         i_mode  = M_NAME;
         i_start = 1'b1;
      end else if (is_digit) begin
         i_mode  = M_NUMBER;
         i_start = 1'b1;
      end else begin
         unique case (char_code)
            CH_QUOTE: begin
               i_mode  = M_STRING;
               i_start = 1'b1;
            end
            CH_LBRACE: i_mode = M_BRACE;
            CH_SLASH:  i_mode = M_SLASH;
            CH_COLON: begin
               i_mode  = M_COLON;
               i_start = 1'b1;
            end
            CH_GT: begin
               i_mode  = M_GT;
               i_start = 1'b1;
            end
            CH_LT: begin
               i_mode  = M_LT;
               i_start = 1'b1;
            end
            CH_PLUS: begin
               i_emit = 1'b1;
               i_kind = KIND_PLUS;
            end
            CH_MINUS: begin
               i_emit = 1'b1;
               i_kind = KIND_MINUS;
            end
            CH_STAR: begin
               i_emit = 1'b1;
               i_kind = KIND_TIMES;
            end
            CH_EQUAL: begin
               i_emit = 1'b1;
               i_kind = KIND_EQUAL;
            end
            CH_LPAREN: begin
               i_emit = 1'b1;
               i_kind = KIND_LPAREN;
            end
            CH_RPAREN: begin
               i_emit = 1'b1;
               i_kind = KIND_RPAREN;
            end
            CH_LBRACKET: begin
               i_emit = 1'b1;
               i_kind = KIND_LBRACKET;
            end
            CH_RBRACKET: begin
               i_emit = 1'b1;
               i_kind = KIND_RBRACKET;
            end
            CH_PERIOD: begin
               i_emit = 1'b1;
               i_kind = KIND_PERIOD;
            end
            CH_COMMA: begin
               i_emit = 1'b1;
               i_kind = KIND_COMMA;
            end
            CH_SEMI: begin
               i_emit = 1'b1;
               i_kind = KIND_SEMI;
            end
            default: begin
               i_emit = 1'b1;
               i_err  = ERR_UNEXPECTED;
            end
         endcase
      end
   end

   // Next state.
   always_comb begin
      mode_in  = mode_ff;
      nl_in    = nl_ff;
      line_in  = line_ff;
      len_in   = len_ff;
      run_idle = 1'b0;
      take_nl  = 1'b0;
      if (accept) begin
         if (end_marker) begin
            mode_in = M_IDLE;
            nl_in   = NL_NONE;
            line_in = LINE_BITS'(1);
            len_in  = '0;
         end else begin
            nl_in = NL_NONE;
            if (!absorbed) begin
               unique case (mode_ff)
                  M_NAME: begin
                     if (is_alnum) len_in = len_inc;
                     else run_idle = 1'b1;
                  end
                  M_NUMBER: begin
                     if (is_digit) len_in = len_inc;
                     else run_idle = 1'b1;
                  end
                  M_COLON, M_GT: begin
                     if (char_code == CH_EQUAL) mode_in = M_IDLE;
                     else run_idle = 1'b1;
                  end
                  M_LT: begin
                     if ((char_code == CH_GT) || (char_code == CH_EQUAL)) mode_in = M_IDLE;
                     else run_idle = 1'b1;
                  end
                  M_SLASH: begin
                     mode_in = (char_code == CH_STAR) ? M_STAR : M_IDLE;
                  end
                  M_BRACE: begin
                     if (char_code == CH_RBRACE) mode_in = M_IDLE;
                     else if (is_nl) take_nl = 1'b1;
                     else if (!is_graph) mode_in = M_IDLE;
                  end
                  M_STAR, M_STARSTAR: begin
                     if ((char_code == CH_SLASH) && (mode_ff == M_STARSTAR)) begin
                        mode_in = M_IDLE;
                     end else if (char_code == CH_STAR) begin
                        mode_in = M_STARSTAR;
                     end else if (is_nl) begin
                        take_nl = 1'b1;
                        mode_in = M_STAR;
                     end else if (is_graph) begin
                        mode_in = M_STAR;
                     end else begin
                        mode_in = M_IDLE;
                     end
                  end
                  M_STRING: begin
                     if (char_code == CH_QUOTE) begin
                        len_in  = len_inc;
                        mode_in = M_QUOTE;
                     end else if (is_nl || !is_graph) begin
                        mode_in = M_IDLE;
                     end else begin
                        len_in = len_inc;
                     end
                  end
                  M_QUOTE: begin
                     if (char_code == CH_QUOTE) begin
                        len_in  = len_inc;
                        mode_in = M_STRING;
                     end else begin
                        run_idle = 1'b1;
                     end
                  end
                  default: run_idle = 1'b1;
               endcase
               if (run_idle) begin
                  mode_in = i_mode;
                  if (i_start) len_in = LENGTH_BITS'(1);
                  if (i_nl) take_nl = 1'b1;
               end
               if (take_nl) begin
                  line_in = line_inc;
                  nl_in   = (char_code == CH_LF) ? NL_AFTER_LF : NL_AFTER_CR;
               end
            end
         end
      end
   end

   // Results of the step.
   always_comb begin
      tok_v    = 1'b0;
      tok_idle = 1'b0;
      tok_kind = KIND_NAME;
      tok_err  = ERR_OK;
      tok_len  = '0;
      if (end_marker) begin
         unique case (mode_ff)
            M_NAME: begin
               tok_v   = 1'b1;
               tok_len = len_ff;
            end
            M_NUMBER: begin
               tok_v    = 1'b1;
               tok_kind = KIND_NUMBER;
               tok_len  = len_ff;
            end
            M_COLON: begin
               tok_v    = 1'b1;
               tok_kind = KIND_COLON;
               tok_len  = LENGTH_BITS'(1);
            end
            M_GT: begin
               tok_v    = 1'b1;
               tok_kind = KIND_GT;
               tok_len  = LENGTH_BITS'(1);
            end
            M_LT: begin
               tok_v    = 1'b1;
               tok_kind = KIND_LT;
               tok_len  = LENGTH_BITS'(1);
            end
            M_QUOTE: begin
               tok_v    = 1'b1;
               tok_kind = KIND_STRING;
               tok_len  = len_ff;
            end
            M_SLASH: begin
               tok_v   = 1'b1;
               tok_err = ERR_UNEXPECTED;
            end
            M_BRACE, M_STAR, M_STARSTAR, M_STRING: begin
               tok_v   = 1'b1;
               tok_err = ERR_UNTERMINATED;
            end
            default: tok_v = 1'b0;
         endcase
      end else if (!absorbed) begin
         unique case (mode_ff)
            M_NAME: begin
               tok_v    = !is_alnum;
               tok_idle = !is_alnum;
               tok_len  = len_ff;
            end
            M_NUMBER: begin
               tok_v    = !is_digit;
               tok_idle = !is_digit;
               tok_kind = KIND_NUMBER;
               tok_len  = len_ff;
            end
            M_COLON: begin
               tok_v = 1'b1;
               if (char_code == CH_EQUAL) begin
                  tok_kind = KIND_BECOMES;
                  tok_len  = LENGTH_BITS'(2);
               end else begin
                  tok_idle = 1'b1;
                  tok_kind = KIND_COLON;
                  tok_len  = LENGTH_BITS'(1);
               end
            end
            M_GT: begin
               tok_v = 1'b1;
               if (char_code == CH_EQUAL) begin
                  tok_kind = KIND_GE;
                  tok_len  = LENGTH_BITS'(2);
               end else begin
                  tok_idle = 1'b1;
                  tok_kind = KIND_GT;
                  tok_len  = LENGTH_BITS'(1);
               end
            end
            M_LT: begin
               tok_v = 1'b1;
               if (char_code == CH_GT) begin
                  tok_kind = KIND_NE;
                  tok_len  = LENGTH_BITS'(2);
               end else if (char_code == CH_EQUAL) begin
                  tok_kind = KIND_LE;
                  tok_len  = LENGTH_BITS'(2);
               end else begin
                  tok_idle = 1'b1;
                  tok_kind = KIND_LT;
                  tok_len  = LENGTH_BITS'(1);
               end
            end
            M_SLASH: begin
               tok_v   = (char_code != CH_STAR);
               tok_err = ERR_UNEXPECTED;
            end
            M_BRACE: begin
               tok_v   = (char_code != CH_RBRACE) && !is_graph;
               tok_err = ERR_BAD_CHAR;
            end
            M_STAR, M_STARSTAR: begin
               tok_v   = !is_graph;
               tok_err = ERR_BAD_CHAR;
            end
            M_STRING: begin
               tok_v   = (char_code != CH_QUOTE) && (is_nl || !is_graph);
               tok_err = ERR_BAD_CHAR;
            end
            M_QUOTE: begin
               tok_v    = (char_code != CH_QUOTE);
               tok_idle = (char_code != CH_QUOTE);
               tok_kind = KIND_STRING;
               tok_len  = len_ff;
            end
            default: tok_idle = 1'b1;
         endcase
      end
   end

   always_comb begin
      step        = '0;
      step_length = '0;
      step_push   = 1'b0;
      if (tok_v) begin
         step_push   = accept;
         step.kind0  = tok_kind;
         step.err0   = tok_err;
         step_length = tok_len;
         step.two    = tok_idle && i_emit;
         step.kind1  = i_kind;
         step.err1   = i_err;
      end else if (tok_idle && i_emit) begin
         step_push   = accept;
         step.kind0  = i_kind;
         step.err0   = i_err;
         step_length = (i_err == ERR_OK) ? LENGTH_BITS'(1) : '0;
      end
   end

   assign step_line = line_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= M_IDLE;
         nl_ff   <= NL_NONE;
         line_ff <= LINE_BITS'(1);
         len_ff  <= '0;
      end else begin
         mode_ff <= mode_in;
         nl_ff   <= nl_in;
         line_ff <= line_in;
         len_ff  <= len_in;
      end
   end

endmodule

>>> rtl/pls_queue.sv
// Four-entry queue of step records between the scanner front end and the result
// serializer, with the line count and first token length carried alongside.
// Depends on pls_pkg.
module pls_queue #(
   parameter int LINE_BITS   = 16,
   parameter int LENGTH_BITS = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  pls_pkg::step_type      step_in,
   input  logic [LENGTH_BITS-1:0] length_in,
   input  logic [LINE_BITS-1:0]   line_in,
   output logic                   full,
   input  logic                   pop,
   output logic                   empty,
   output pls_pkg::step_type      step_out,
   output logic [LENGTH_BITS-1:0] length_out,
   output logic [LINE_BITS-1:0]   line_out
);
   import pls_pkg::*;

   step_type               step_mem [QUEUE_DEPTH];
   logic [LENGTH_BITS-1:0] length_mem [QUEUE_DEPTH];
   logic [LINE_BITS-1:0]   line_mem [QUEUE_DEPTH];

   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_BITS-1:0] count_ff, count_in;
   logic                      do_push, do_pop;

   assign full    = (count_ff == QUEUE_CNT_BITS'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   assign wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
   assign count_in  = count_ff + QUEUE_CNT_BITS'(do_push) - QUEUE_CNT_BITS'(do_pop);

   assign step_out   = step_mem[rd_ptr_ff];
   assign length_out = length_mem[rd_ptr_ff];
   assign line_out   = line_mem[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         step_mem[wr_ptr_ff]   <= step_in;
         length_mem[wr_ptr_ff] <= length_in;
         line_mem[wr_ptr_ff]   <= line_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> rtl/pls_back.sv
// Result serializer: presents the one or two results of the oldest queued step
// record one at a time and releases the record after its last transfer.
// Depends on pls_pkg.
module pls_back #(
   parameter int LINE_BITS   = 16,
   parameter int LENGTH_BITS = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_empty,
   input  pls_pkg::step_type      q_step,
   input  logic [LENGTH_BITS-1:0] q_length,
   input  logic [LINE_BITS-1:0]   q_line,
   output logic                   q_pop,
   input  logic                   pop,
   output logic [4:0]             token_kind,
   output logic [LENGTH_BITS-1:0] token_length,
   output logic [LINE_BITS-1:0]   line_number,
   output logic [1:0]             error_code,
   output logic                   last
);
   import pls_pkg::*;

   logic sel_ff, sel_in, fire;

   assign fire  = pop && !q_empty;
   assign q_pop = fire && (sel_ff || !q_step.two);

   always_comb begin
      sel_in = sel_ff;
      if (fire) sel_in = !sel_ff && q_step.two;
   end

   assign token_kind   = sel_ff ? q_step.kind1 : q_step.kind0;
   assign error_code   = sel_ff ? 2'(q_step.err1) : 2'(q_step.err0);
   assign token_length = sel_ff ? ((q_step.err1 == ERR_OK) ? LENGTH_BITS'(1) : '0) : q_length;
   assign line_number  = q_line;
   assign last         = sel_ff || !q_step.two;

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff <= 1'b0;
      end else begin
         sel_ff <= sel_in;
      end
   end

endmodule
